FILE: hdl/xdb_pkg.sv
package xdb_pkg;

   localparam int ID_BITS      = 64;
   localparam int ADDRESS_BITS = 32;
   localparam int TIME_BITS    = 32;
   localparam int BUCKET_SIZE  = 16;
   localparam int SLOT_BITS    = 4;
   localparam int NUM_BUCKETS  = 64;
   localparam int BUCKET_BITS  = 6;
   localparam int STORE_DEPTH  = NUM_BUCKETS * BUCKET_SIZE;
   localparam int STORE_ABITS  = BUCKET_BITS + SLOT_BITS;
   localparam int FILL_BITS    = 5;
   localparam int MAX_LISTED   = 64;
   localparam int LIMIT_BITS   = 7;
   localparam int COUNT_BITS   = STORE_ABITS + 1;
   localparam int KEY_BITS     = ID_BITS + STORE_ABITS;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [1:0] OP_UPSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_SWEEP  = 2'd2;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_REFRESHED = 3'd1;
   localparam logic [2:0] ST_EVICTED   = 3'd2;
   localparam logic [2:0] ST_OWN_ID    = 3'd3;
   localparam logic [2:0] ST_LISTED    = 3'd4;
   localparam logic [2:0] ST_NONE      = 3'd5;
   localparam logic [2:0] ST_SWEPT     = 3'd6;

   localparam logic REG_OWN_ID = 1'b0;

   typedef struct packed {
      logic [ID_BITS-1:0]      ident;
      logic [ADDRESS_BITS-1:0] addr;
      logic [TIME_BITS-1:0]    expiry;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic [2:0]              status;
      logic [ID_BITS-1:0]      ident;
      logic [ADDRESS_BITS-1:0] addr;
      logic [TIME_BITS-1:0]    expiry;
      logic [ID_BITS-1:0]      distance;
      logic                    last;
   } result_type;

endpackage

FILE: hdl/xdb_req_if.sv
interface xdb_req_if;
   import xdb_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [1:0]              operation;
   logic [ID_BITS-1:0]      peer_identifier;
   logic [ADDRESS_BITS-1:0] peer_address;
   logic [TIME_BITS-1:0]    expiry_time;
   logic [TIME_BITS-1:0]    current_time;
   logic [LIMIT_BITS-1:0]   result_limit;
   modport source (output valid, operation, peer_identifier, peer_address, expiry_time,
                   current_time, result_limit, input ready);
   modport sink (input valid, operation, peer_identifier, peer_address, expiry_time,
                 current_time, result_limit, output ready);
endinterface

FILE: hdl/xdb_rsp_if.sv
interface xdb_rsp_if;
   import xdb_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [2:0]              status;
   logic [ID_BITS-1:0]      listed_identifier;
   logic [ADDRESS_BITS-1:0] listed_address;
   logic [TIME_BITS-1:0]    listed_expiry;
   logic [ID_BITS-1:0]      listed_distance;
   logic                    last_of_run;
   modport source (output valid, status, listed_identifier, listed_address, listed_expiry,
                   listed_distance, last_of_run, input ready);
   modport sink (input valid, status, listed_identifier, listed_address, listed_expiry,
                 listed_distance, last_of_run, output ready);
endinterface

FILE: hdl/xor_distance_bucket_table_core.sv
// upsert: msb search, then bucket compaction and append
// query: one pass per listed peer (one if none listed, none for limit zero), each pass
// over the 1024-entry store, one read a cycle
// sweep: one compaction pass per bucket over 64 buckets; one word at a time, next word after the last
// each word waits in the output register until taken
// reset clears control, bucket fill valid bits and own identifier; the store has no clearing pass
module xor_distance_bucket_table_core (
   input  logic                              clock,
   input  logic                              reset,
   xdb_req_if.sink                           req_chan,
   xdb_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [xdb_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [xdb_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [xdb_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready
);
   import xdb_pkg::*;

   logic [ID_BITS-1:0] own_id;

   xdb_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .own_id(own_id)
   );

   xdb_engine u_engine (
      .clock(clock), .reset(reset), .own_id(own_id),
      .req_chan(req_chan), .rsp_chan(rsp_chan)
   );
endmodule

FILE: hdl/xdb_ram.sv
module xdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/xdb_csr.sv
module xdb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [xdb_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [xdb_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [xdb_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready,
   output logic [xdb_pkg::ID_BITS-1:0]        own_id
);
   import xdb_pkg::*;

   logic [ID_BITS-1:0] own_id_ff, own_id_in;
   logic               sel_own;

   assign sel_own = (paddr[CSR_ADDR_BITS-1] == REG_OWN_ID);

   always_comb begin
      own_id_in = own_id_ff;
      if (psel && penable && pwrite && sel_own) begin
         own_id_in = pwdata[ID_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= '0;
      end else begin
         own_id_ff <= own_id_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = sel_own ? CSR_DATA_BITS'(own_id_ff) : '0;
   assign own_id = own_id_ff;
endmodule

FILE: hdl/xdb_engine.sv
module xdb_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [xdb_pkg::ID_BITS-1:0] own_id,
   xdb_req_if.sink                     req_chan,
   xdb_rsp_if.source                   rsp_chan
);
   import xdb_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_FILL, S_FILLW, S_PURGE, S_APPEND, S_QSCAN, S_QEND, S_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic [1:0]              op_ff, op_in;
   logic [ID_BITS-1:0]      id_ff, id_in;
   logic [ADDRESS_BITS-1:0] paddr_ff, paddr_in;
   logic [TIME_BITS-1:0]    exp_ff, exp_in;
   logic [TIME_BITS-1:0]    now_ff, now_in;
   logic [LIMIT_BITS-1:0]   limit_ff, limit_in;
   logic [LIMIT_BITS-1:0]   take_ff, take_in;
   logic [LIMIT_BITS-1:0]   listed_ff, listed_in;
   logic [ID_BITS-1:0]      diff_ff, diff_in;
   logic [BUCKET_BITS-1:0]  bucket_ff, bucket_in;
   logic [FILL_BITS-1:0]    n_ff, n_in, r_ff, r_in, w_ff, w_in;
   logic                    pv_ff, pv_in;
   logic                    matched_ff, matched_in;
   logic                    evict_ff, evict_in;
   logic [COUNT_BITS-1:0]   scan_ff, scan_in, count_ff, count_in;
   logic [STORE_ABITS-1:0]  sa_ff, sa_in;
   logic                    first_ff, first_in;
   logic                    found_ff, found_in;
   logic [KEY_BITS-1:0]     best_key_ff, best_key_in, last_key_ff, last_key_in;
   entry_type               best_ent_ff, best_ent_in;
   result_type              out_ff, out_in;
   logic [NUM_BUCKETS-1:0]  fill_vld_ff, fill_vld_in;
   logic                    fill_rvld_ff;

   logic                    ram_we;
   logic [STORE_ABITS-1:0]  ram_wr_addr, ram_rd_addr;
   logic [ENTRY_BITS-1:0]   ram_wr_data, ram_rd_data;
   logic                    fill_we;
   logic [BUCKET_BITS-1:0]  fill_wr_addr, fill_rd_addr;
   logic [FILL_BITS-1:0]    fill_wr_data, fill_rd_data, fill_eff;

   entry_type               ent;
   logic                    live, hit, keep, in_bucket, cand;
   logic [KEY_BITS-1:0]     key;
   logic [LIMIT_BITS-1:0]   take_c;
   result_type              res_none;

   xdb_ram #(.WIDTH(ENTRY_BITS), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .we(ram_we), .wr_addr(ram_wr_addr), .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr), .rd_data(ram_rd_data)
   );

   xdb_ram #(.WIDTH(FILL_BITS), .DEPTH(NUM_BUCKETS)) u_fill (
      .clock(clock), .we(fill_we), .wr_addr(fill_wr_addr), .wr_data(fill_wr_data),
      .rd_addr(fill_rd_addr), .rd_data(fill_rd_data)
   );

   assign ent       = entry_type'(ram_rd_data);
   assign fill_eff  = fill_rvld_ff ? fill_rd_data : '0;
   assign live      = now_ff < ent.expiry;
   assign key       = {ent.ident ^ id_ff, sa_ff};
   assign in_bucket = {1'b0, sa_ff[SLOT_BITS-1:0]} < fill_eff;
   assign hit       = (op_ff == OP_UPSERT) && !matched_ff && (ent.ident == id_ff) && live;
   assign keep      = evict_ff || (live && !hit);
   assign cand      = in_bucket && live && (first_ff || key > last_key_ff);
   assign take_c    = (count_ff < COUNT_BITS'(limit_ff)) ? count_ff[LIMIT_BITS-1:0]
                                                         : limit_ff;

   always_comb begin
      res_none        = '0;
      res_none.status = ST_NONE;
      res_none.last   = 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      paddr_in     = paddr_ff;
      exp_in       = exp_ff;
      now_in       = now_ff;
      limit_in     = limit_ff;
      take_in      = take_ff;
      listed_in    = listed_ff;
      diff_in      = diff_ff;
      bucket_in    = bucket_ff;
      n_in         = n_ff;
      r_in         = r_ff;
      w_in         = w_ff;
      pv_in        = pv_ff;
      matched_in   = matched_ff;
      evict_in     = evict_ff;
      scan_in      = scan_ff;
      count_in     = count_ff;
      sa_in        = sa_ff;
      first_in     = first_ff;
      found_in     = found_ff;
      best_key_in  = best_key_ff;
      last_key_in  = last_key_ff;
      best_ent_in  = best_ent_ff;
      out_in       = out_ff;
      fill_vld_in  = fill_vld_ff;
      ram_we       = 1'b0;
      ram_wr_addr  = {bucket_ff, w_ff[SLOT_BITS-1:0]};
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = {bucket_ff, r_ff[SLOT_BITS-1:0]};
      fill_we      = 1'b0;
      fill_wr_addr = bucket_ff;
      fill_wr_data = w_ff;
      fill_rd_addr = bucket_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in     = req_chan.operation;
               id_in     = req_chan.peer_identifier;
               paddr_in  = req_chan.peer_address;
               exp_in    = req_chan.expiry_time;
               now_in    = req_chan.current_time;
               limit_in  = (req_chan.result_limit > LIMIT_BITS'(MAX_LISTED))
                           ? LIMIT_BITS'(MAX_LISTED) : req_chan.result_limit;
               diff_in   = req_chan.peer_identifier ^ own_id;
               bucket_in = BUCKET_BITS'(NUM_BUCKETS - 1);
               evict_in  = 1'b0;
               out_in    = res_none;
               unique case (req_chan.operation)
                  OP_UPSERT: state_in = S_FIND;
                  OP_QUERY: begin
                     scan_in   = '0;
                     pv_in     = 1'b0;
                     first_in  = 1'b1;
                     count_in  = '0;
                     found_in  = 1'b0;
                     listed_in = '0;
                     state_in  = (req_chan.result_limit == '0) ? S_OUT : S_QSCAN;
                  end
                  OP_SWEEP: begin
                     bucket_in = '0;
                     state_in  = S_FILL;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_FIND: begin
            if (diff_ff == '0) begin
               out_in.status = ST_OWN_ID;
               state_in      = S_OUT;
            end else if (diff_ff[ID_BITS-1]) begin
               state_in = S_FILL;
            end else begin
               diff_in   = diff_ff << 1;
               bucket_in = bucket_ff - 1'b1;
            end
         end
         S_FILL: begin
            state_in = S_FILLW;
         end
         S_FILLW: begin
            n_in       = fill_eff;
            r_in       = '0;
            w_in       = '0;
            pv_in      = 1'b0;
            matched_in = 1'b0;
            state_in   = S_PURGE;
         end
         S_PURGE: begin
            if (pv_ff) begin
               if (hit) begin
                  matched_in = 1'b1;
               end
               if (keep) begin
                  ram_we = 1'b1;
                  w_in   = w_ff + 1'b1;
               end
            end
            if (r_ff < n_ff) begin
               r_in  = r_ff + 1'b1;
               pv_in = 1'b1;
            end else begin
               pv_in = 1'b0;
            end
            if (!pv_ff && r_ff >= n_ff) begin
               if (op_ff == OP_SWEEP) begin
                  fill_we               = 1'b1;
                  fill_vld_in[bucket_ff] = 1'b1;
                  if (bucket_ff == BUCKET_BITS'(NUM_BUCKETS - 1)) begin
                     out_in.status = ST_SWEPT;
                     state_in      = S_OUT;
                  end else begin
                     bucket_in = bucket_ff + 1'b1;
                     state_in  = S_FILL;
                  end
               end else if (evict_ff) begin
                  state_in = S_APPEND;
               end else if (matched_ff) begin
                  out_in.status = ST_REFRESHED;
                  state_in      = S_APPEND;
               end else if (w_ff >= FILL_BITS'(BUCKET_SIZE)) begin
                  out_in.status = ST_EVICTED;
                  evict_in      = 1'b1;
                  n_in          = FILL_BITS'(BUCKET_SIZE);
                  r_in          = FILL_BITS'(1);
                  w_in          = '0;
               end else begin
                  out_in.status = ST_INSERTED;
                  state_in      = S_APPEND;
               end
            end
         end
         S_APPEND: begin
            ram_we                 = 1'b1;
            ram_wr_data            = {id_ff, paddr_ff, exp_ff};
            fill_we                = 1'b1;
            fill_wr_data           = w_ff + 1'b1;
            fill_vld_in[bucket_ff] = 1'b1;
            state_in               = S_OUT;
         end
         S_QSCAN: begin
            ram_rd_addr  = scan_ff[STORE_ABITS-1:0];
            fill_rd_addr = scan_ff[STORE_ABITS-1:SLOT_BITS];
            if (pv_ff) begin
               if (first_ff && in_bucket && live) begin
                  count_in = count_ff + 1'b1;
               end
               if (cand && (!found_ff || key < best_key_ff)) begin
                  found_in    = 1'b1;
                  best_key_in = key;
                  best_ent_in = ent;
               end
            end
            if (!scan_ff[COUNT_BITS-1]) begin
               sa_in   = scan_ff[STORE_ABITS-1:0];
               pv_in   = 1'b1;
               scan_in = scan_ff + 1'b1;
            end else begin
               pv_in = 1'b0;
               if (!pv_ff) begin
                  state_in = S_QEND;
               end
            end
         end
         S_QEND: begin
            state_in = S_OUT;
            if (first_ff && take_c == '0) begin
               out_in = res_none;
            end else begin
               if (first_ff) begin
                  take_in = take_c;
               end
               listed_in       = listed_ff + 1'b1;
               out_in.status   = ST_LISTED;
               out_in.ident    = best_ent_ff.ident;
               out_in.addr     = best_ent_ff.addr;
               out_in.expiry   = best_ent_ff.expiry;
               out_in.distance = best_key_ff[KEY_BITS-1:STORE_ABITS];
               out_in.last     = (listed_ff + 1'b1) == (first_ff ? take_c : take_ff);
            end
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               if (out_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  scan_in     = '0;
                  pv_in       = 1'b0;
                  first_in    = 1'b0;
                  found_in    = 1'b0;
                  last_key_in = best_key_ff;
                  state_in    = S_QSCAN;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fill_vld_ff <= '0;
         pv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_vld_ff <= fill_vld_in;
         pv_ff       <= pv_in;
      end
      fill_rvld_ff <= fill_vld_ff[fill_rd_addr];
      op_ff        <= op_in;
      id_ff        <= id_in;
      paddr_ff     <= paddr_in;
      exp_ff       <= exp_in;
      now_ff       <= now_in;
      limit_ff     <= limit_in;
      take_ff      <= take_in;
      listed_ff    <= listed_in;
      diff_ff      <= diff_in;
      bucket_ff    <= bucket_in;
      n_ff         <= n_in;
      r_ff         <= r_in;
      w_ff         <= w_in;
      matched_ff   <= matched_in;
      evict_ff     <= evict_in;
      scan_ff      <= scan_in;
      count_ff     <= count_in;
      sa_ff        <= sa_in;
      first_ff     <= first_in;
      found_ff     <= found_in;
      best_key_ff  <= best_key_in;
      last_key_ff  <= last_key_in;
      best_ent_ff  <= best_ent_in;
      out_ff       <= out_in;
   end

   assign req_chan.ready             = (state_ff == S_IDLE);
   assign rsp_chan.valid             = (state_ff == S_OUT);
   assign rsp_chan.status            = out_ff.status;
   assign rsp_chan.listed_identifier = out_ff.ident;
   assign rsp_chan.listed_address    = out_ff.addr;
   assign rsp_chan.listed_expiry     = out_ff.expiry;
   assign rsp_chan.listed_distance   = out_ff.distance;
   assign rsp_chan.last_of_run       = out_ff.last;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_we |-> (fill_wr_data <= FILL_BITS'(BUCKET_SIZE)))
      else $error("bucket fill above bucket size");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PURGE) |-> (w_ff <= r_ff))
      else $error("compaction write ahead of read");

   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QSCAN || state_ff == S_QEND) |-> !ram_we)
      else $error("store written during query");

   a_next_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_of_run) |=> (state_ff == S_QSCAN))
      else $error("listing ended without last word");
endmodule

FILE: tb/tb.sv
module tb;
   import xdb_pkg::*;

   localparam int CYCLE_LIMIT = 40000000;

   class bucket_table_scoreboard;
      logic [ID_BITS-1:0] own_id;
      entry_type          contacts [NUM_BUCKETS][BUCKET_SIZE];
      int unsigned        fill [NUM_BUCKETS];
      result_type         pending [$];
      int                 errors;
      int                 words_seen;
      int                 listed_seen;

      function new();
         own_id = '0;
         errors = 0;
         words_seen = 0;
         listed_seen = 0;
         foreach (fill[b]) fill[b] = 0;
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      function void purge(int b, logic [TIME_BITS-1:0] now);
         int unsigned w;
         w = 0;
         for (int r = 0; r < fill[b]; r++) begin
            if (now < contacts[b][r].expiry) begin
               contacts[b][w] = contacts[b][r];
               w++;
            end
         end
         fill[b] = w;
      endfunction

      function void drop(int b, int pos);
         for (int i = pos; i + 1 < fill[b]; i++) contacts[b][i] = contacts[b][i+1];
         fill[b]--;
      endfunction

      function void push_word(logic [2:0] st, entry_type e, logic [ID_BITS-1:0] d, bit last);
         result_type r;
         r.status = st;
         r.ident = e.ident;
         r.addr = e.addr;
         r.expiry = e.expiry;
         r.distance = d;
         r.last = last;
         pending.insert(pending.size(), r);
      endfunction

      function logic [2:0] upsert(entry_type e, logic [TIME_BITS-1:0] now);
         logic [ID_BITS-1:0] diff;
         int b;
         diff = e.ident ^ own_id;
         if (diff == '0) return ST_OWN_ID;
         b = 0;
         for (int i = 0; i < ID_BITS; i++) if (diff[i]) b = i;
         purge(b, now);
         for (int i = 0; i < fill[b]; i++) begin
            if (contacts[b][i].ident == e.ident) begin
               drop(b, i);
               contacts[b][fill[b]] = e;
               fill[b]++;
               return ST_REFRESHED;
            end
         end
         if (fill[b] >= BUCKET_SIZE) begin
            drop(b, 0);
            contacts[b][fill[b]] = e;
            fill[b]++;
            return ST_EVICTED;
         end
         contacts[b][fill[b]] = e;
         fill[b]++;
         return ST_INSERTED;
      endfunction

      function void query(logic [ID_BITS-1:0] target, int unsigned limit,
                          logic [TIME_BITS-1:0] now);
         entry_type          found [$];
         logic [ID_BITS-1:0] dist_q [$];
         logic [ID_BITS-1:0] d;
         entry_type          zero_entry;
         int                 j, take;
         zero_entry = '0;
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            for (int i = 0; i < fill[b]; i++) begin
               if (now >= contacts[b][i].expiry) continue;
               d = contacts[b][i].ident ^ target;
               j = dist_q.size();
               while (j > 0 && dist_q[j-1] > d) j--;
               found.insert(j, contacts[b][i]);
               dist_q.insert(j, d);
            end
         end
         if (limit > MAX_LISTED) limit = MAX_LISTED;
         take = (limit < found.size()) ? limit : found.size();
         if (take == 0) push_word(ST_NONE, zero_entry, '0, 1'b1);
         for (int i = 0; i < take; i++) push_word(ST_LISTED, found[i], dist_q[i], i + 1 == take);
      endfunction

      function void note(logic [1:0] op, logic [ID_BITS-1:0] id, logic [ADDRESS_BITS-1:0] addr,
                         logic [TIME_BITS-1:0] expiry, logic [TIME_BITS-1:0] now,
                         logic [LIMIT_BITS-1:0] limit);
         entry_type e, zero_entry;
         zero_entry = '0;
         e.ident = id;
         e.addr = addr;
         e.expiry = expiry;
         case (op)
            OP_UPSERT: push_word(upsert(e, now), zero_entry, '0, 1'b1);
            OP_QUERY: query(id, limit, now);
            OP_SWEEP: begin
               for (int b = 0; b < NUM_BUCKETS; b++) purge(b, now);
               push_word(ST_SWEPT, zero_entry, '0, 1'b1);
            end
            default: push_word(ST_NONE, zero_entry, '0, 1'b1);
         endcase
      endfunction

      task check(result_type got);
         result_type want;
         words_seen++;
         if (got.status == ST_LISTED) listed_seen++;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word status %0d", got.status));
            return;
         end
         want = pending[0];
         pending.delete(0);
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.ident !== want.ident)
            report($sformatf("identifier %h, want %h", got.ident, want.ident));
         if (got.addr !== want.addr)
            report($sformatf("address %h, want %h", got.addr, want.addr));
         if (got.expiry !== want.expiry)
            report($sformatf("expiry %h, want %h", got.expiry, want.expiry));
         if (got.distance !== want.distance)
            report($sformatf("distance %h, want %h", got.distance, want.distance));
         if (got.last !== want.last)
            report($sformatf("last %b, want %b", got.last, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   xdb_req_if req ();
   xdb_rsp_if rsp ();

   xor_distance_bucket_table_core dut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   bucket_table_scoreboard table_sb = new();
   int unsigned cycles = 0;
   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   int unsigned stall_mode = 0;
   logic [TIME_BITS-1:0] clock_now = 100;
   logic [ID_BITS-1:0] id_pool [$];

   initial begin
      req.valid = 1'b0;
      req.operation = OP_UPSERT;
      req.peer_identifier = '0;
      req.peer_address = '0;
      req.expiry_time = '0;
      req.current_time = '0;
      req.result_limit = '0;
      rsp.ready = 1'b0;
   end

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb failed");
         $finish;
      end
   end

   // receiver stall pattern: free, random, or mostly stalled, chosen at random
   always @(posedge clock) begin
      if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= 1'($urandom_range(0, 1));
         default: rsp.ready <= ($urandom_range(0, 3) == 0);
      endcase
      if (!reset && rsp.valid && rsp.ready)
         table_sb.check({rsp.status, rsp.listed_identifier, rsp.listed_address,
                         rsp.listed_expiry, rsp.listed_distance, rsp.last_of_run});
   end

   task automatic write_own_id(logic [ID_BITS-1:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'(8 * REG_OWN_ID);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      table_sb.own_id = value;
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (table_sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic send(logic [1:0] op, logic [ID_BITS-1:0] id, logic [ADDRESS_BITS-1:0] addr,
                       logic [TIME_BITS-1:0] expiry, logic [TIME_BITS-1:0] now,
                       logic [LIMIT_BITS-1:0] limit);
      req.operation <= op;
      req.peer_identifier <= id;
      req.peer_address <= addr;
      req.expiry_time <= expiry;
      req.current_time <= now;
      req.result_limit <= limit;
      req.valid <= 1'b1;
      do @(posedge clock); while (!req.ready);
      table_sb.note(op, id, addr, expiry, now, limit);
      items_sent++;
      if (burst_left == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_random();
      int unsigned pick;
      logic [ID_BITS-1:0] id;
      logic [TIME_BITS-1:0] now, expiry;
      logic [LIMIT_BITS-1:0] limit;
      clock_now = clock_now + $urandom_range(0, 3);
      now = clock_now;
      expiry = clock_now + $urandom_range(0, 60);
      if ($urandom_range(0, 19) == 0) now = $urandom();
      if ($urandom_range(0, 9) == 0) expiry = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) id = table_sb.own_id ^ ID_BITS'($urandom_range(16, 31));
         else if (pick < 55) id = table_sb.own_id ^ ID_BITS'($urandom_range(32, 63));
         else if (pick < 75 && id_pool.size() > 0)
            id = id_pool[$urandom_range(0, id_pool.size()-1)];
         else if (pick < 80) id = table_sb.own_id;
         else id = {$urandom(), $urandom()};
         if (id_pool.size() < 64) id_pool.insert(id_pool.size(), id);
         send(OP_UPSERT, id, $urandom(), expiry, now, LIMIT_BITS'($urandom()));
      end else if (pick < 85) begin
         limit = ($urandom_range(0, 19) == 0) ? LIMIT_BITS'($urandom_range(0, 127))
                                             : LIMIT_BITS'($urandom_range(0, 6));
         id = ($urandom_range(0, 1) == 0) ? table_sb.own_id ^ ID_BITS'($urandom_range(0, 63))
                                          : {$urandom(), $urandom()};
         send(OP_QUERY, id, $urandom(), $urandom(), now, limit);
      end else if (pick < 95) begin
         send(OP_SWEEP, {$urandom(), $urandom()}, $urandom(), $urandom(), now,
              LIMIT_BITS'($urandom()));
      end else begin
         send(2'd3, {$urandom(), $urandom()}, $urandom(), $urandom(), now,
              LIMIT_BITS'($urandom()));
      end
   endtask

   initial begin
      logic [ID_BITS-1:0] phase_ids [3];
      phase_ids[0] = '0;
      phase_ids[1] = '1;
      phase_ids[2] = {$urandom(), $urandom()};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_own_id('0);
      send(OP_QUERY, '0, '0, '0, 32'd0, 7'd5);
      send(OP_UPSERT, '0, 32'h1234, 32'd50, 32'd0, '0);
      send(OP_UPSERT, '1, '1, '1, 32'd0, '0);
      send(OP_UPSERT, 64'd1, 32'd7, 32'd0, 32'd0, '0);
      send(OP_UPSERT, 64'd1, 32'd8, 32'd200, 32'd10, '0);
      send(OP_UPSERT, 64'd3, 32'd9, 32'd150, 32'd10, '0);
      send(OP_UPSERT, 64'd2, 32'd10, 32'd150, 32'd10, '0);
      send(OP_UPSERT, 64'd1, 32'd11, 32'd300, 32'd20, '0);
      send(OP_QUERY, '0, '0, '0, 32'd20, 7'd0);
      send(OP_QUERY, 64'd0, '0, '0, 32'd20, 7'd64);
      send(OP_QUERY, '1, '0, '0, 32'd20, 7'd127);
      send(2'd3, '1, '1, '1, '1, '1);
      send(OP_SWEEP, '0, '0, '0, 32'd160, '0);
      send(OP_QUERY, 64'd2, '0, '0, 32'd160, 7'd3);
      send(OP_SWEEP, '0, '0, '0, 32'hFFFF_FFFE, '0);
      send(OP_QUERY, 64'd2, '0, '0, 32'd0, 7'd3);

      for (int p = 0; p < 3; p++) begin
         wait_idle();
         write_own_id(phase_ids[p]);
         id_pool.delete();
         for (int n = 0; n < 28; n++) begin
            if (p == 1 && n == 15) begin
               wait_idle();
               burst_left = 0;
            end
            send_random();
         end
      end

      req.valid <= 1'b0;
      while (table_sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("ran %0d items over three own identifiers, %0d words checked, %0d listed peers",
               items_sent, table_sb.words_seen, table_sb.listed_seen);
      if (table_sb.errors == 0) begin
         $display("tb passed");
      end else begin
         $display("%0d mismatches", table_sb.errors);
         $display("tb failed");
      end
      $finish;
   end

endmodule

FILE: xor_distance_bucket_table_core.f
hdl/xdb_pkg.sv
hdl/xdb_req_if.sv
hdl/xdb_rsp_if.sv
hdl/xdb_ram.sv
hdl/xdb_csr.sv
hdl/xdb_engine.sv
hdl/xor_distance_bucket_table_core.sv
tb/tb.sv
